[rtl/meter_reply_frame_receiver_macros.svh]
// ----------------------------------------------------------------------------
// Meter reply frame receiver: assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef METER_REPLY_FRAME_RECEIVER_MACROS_SVH
`define METER_REPLY_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF

// When a holds, b holds in the same cycle
`define MRFR_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// When a holds, b holds in the next cycle
`define MRFR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

// a never holds
`define MRFR_ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("assertion failed: forbidden condition");

`else

`define MRFR_ASSERT_IMPLIES(label, clk, rst, a, b)
`define MRFR_ASSERT_NEXT(label, clk, rst, a, b)
`define MRFR_ASSERT_NEVER(label, clk, rst, a)

`endif

`endif

[rtl/mrfr_pkg.sv]
// ----------------------------------------------------------------------------
// Meter reply frame receiver package
// Widths, codes and shared types of the meter reply frame receiver.
// ----------------------------------------------------------------------------
package mrfr_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int QTY_W     = 2;
  localparam int READING_W = 23;
  localparam int POS_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 2;

  // Frame layout: reply code plus five bytes, then the checksum byte
  localparam logic [POS_W-1:0] POS_HUNT = 3'd0;
  localparam logic [POS_W-1:0] POS_SUM  = 3'd6;

  // Reply codes
  localparam logic [BYTE_W-1:0] CODE_VOLTAGE = 8'hA0;
  localparam logic [BYTE_W-1:0] CODE_CURRENT = 8'hA1;
  localparam logic [BYTE_W-1:0] CODE_POWER   = 8'hA2;
  localparam logic [BYTE_W-1:0] CODE_ENERGY  = 8'hA3;
  localparam logic [BYTE_W-1:0] CODE_ADDR    = 8'hA4;
  localparam logic [BYTE_W-1:0] CODE_ALARM   = 8'hA5;

  // Result status
  localparam logic [STATUS_W-1:0] STATUS_DECODED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  // Quantities
  localparam logic [QTY_W-1:0] QTY_VOLTAGE = 2'd0;
  localparam logic [QTY_W-1:0] QTY_CURRENT = 2'd1;
  localparam logic [QTY_W-1:0] QTY_POWER   = 2'd2;
  localparam logic [QTY_W-1:0] QTY_ADDR    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_REQUEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP_MODE      = 2'd1;

  // Scale factors for the reading
  localparam logic [READING_W-1:0] VOLT_HI_SCALE = 23'd2560;
  localparam logic [READING_W-1:0] VOLT_MID_SCALE = 23'd10;
  localparam logic [READING_W-1:0] CURR_HI_SCALE = 23'd25600;
  localparam logic [READING_W-1:0] CURR_MID_SCALE = 23'd100;

  // Collected frame handed from collector to decoder
  typedef struct packed {
    logic              bad_sum;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } frame_t;

  // Live configuration
  typedef struct packed {
    logic [QTY_W-1:0] pending_request;
    logic             address_setup_mode;
  } cfg_t;

endpackage

[rtl/mrfr_byte_if.sv]
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one serial byte per word.
// ----------------------------------------------------------------------------
interface mrfr_byte_if;
  logic                          valid;
  logic                          ready;
  logic [mrfr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/mrfr_result_if.sv]
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one decoded frame result per word.
// ----------------------------------------------------------------------------
interface mrfr_result_if;
  logic                            valid;
  logic                            ready;
  logic [mrfr_pkg::STATUS_W-1:0]   frame_status;
  logic [mrfr_pkg::QTY_W-1:0]      quantity;
  logic [mrfr_pkg::READING_W-1:0]  reading;
  logic                            matches_request;

  modport source (output valid, output frame_status, output quantity,
                  output reading, output matches_request, input ready);
  modport sink   (input valid, input frame_status, input quantity,
                  input reading, input matches_request, output ready);
endinterface

[rtl/mrfr_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mrfr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mrfr_pkg::CFG_IDX_W-1:0]    index;
  logic [mrfr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mrfr_collector.sv]
// ----------------------------------------------------------------------------
// Frame collector
// Hunts for a reply code, gathers the frame bytes with a running sum and
// registers a finished frame with its checksum verdict.
// ----------------------------------------------------------------------------
module mrfr_collector (
  input  logic                clk,
  input  logic                rst,
  mrfr_byte_if.sink           rx,
  output logic                frame_valid,
  input  logic                frame_ready,
  output mrfr_pkg::frame_t    frame
);

  logic [mrfr_pkg::POS_W-1:0]  byte_position;
  logic [mrfr_pkg::BYTE_W-1:0] running_sum;
  logic [mrfr_pkg::BYTE_W-1:0] code_byte;
  logic [mrfr_pkg::BYTE_W-1:0] byte1;
  logic [mrfr_pkg::BYTE_W-1:0] byte2;
  logic [mrfr_pkg::BYTE_W-1:0] byte3;
  logic                        accept;
  logic                        is_code;
  logic                        last_byte;

  // Only the checksum byte needs room in the frame register
  assign last_byte = (byte_position == mrfr_pkg::POS_SUM);
  assign rx.ready  = !last_byte || !frame_valid || frame_ready;
  assign accept    = rx.valid && rx.ready;
  assign is_code   = (rx.rx_byte >= mrfr_pkg::CODE_VOLTAGE) &&
                     (rx.rx_byte <= mrfr_pkg::CODE_ALARM);

  // Position counter and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= mrfr_pkg::POS_HUNT;
      running_sum   <= '0;
    end else if (accept) begin
      case (byte_position)
        3'd0: begin
          if (is_code) begin
            running_sum   <= rx.rx_byte;
            byte_position <= 3'd1;
          end
        end
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
          running_sum   <= running_sum + rx.rx_byte;
          byte_position <= byte_position + 3'd1;
        end
        3'd6: begin
          running_sum   <= '0;
          byte_position <= mrfr_pkg::POS_HUNT;
        end
        default: begin
          // out of range: hunt again, byte taken as a possible code
          if (is_code) begin
            running_sum   <= rx.rx_byte;
            byte_position <= 3'd1;
          end else begin
            byte_position <= mrfr_pkg::POS_HUNT;
          end
        end
      endcase
    end
  end

  // Frame bytes used by the decoder
  always_ff @(posedge clk) begin
    if (accept) begin
      case (byte_position)
        3'd0:    if (is_code) code_byte <= rx.rx_byte;
        3'd1:    byte1 <= rx.rx_byte;
        3'd2:    byte2 <= rx.rx_byte;
        3'd3:    byte3 <= rx.rx_byte;
        3'd7:    if (is_code) code_byte <= rx.rx_byte;
        default: ;
      endcase
    end
  end

  // Finished frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept && last_byte) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      frame.bad_sum <= (rx.rx_byte != running_sum);
      frame.code    <= code_byte;
      frame.b1      <= byte1;
      frame.b2      <= byte2;
      frame.b3      <= byte3;
    end
  end

endmodule

[rtl/mrfr_decoder.sv]
// ----------------------------------------------------------------------------
// Frame decoder
// Turns a collected frame into a status, quantity and scaled reading and
// holds it in the result register until taken.
// ----------------------------------------------------------------------------
module mrfr_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_ready,
  input  mrfr_pkg::frame_t    frame,
  input  mrfr_pkg::cfg_t      cfg,
  mrfr_result_if.source       result
);

  logic [mrfr_pkg::STATUS_W-1:0]  status_next;
  logic [mrfr_pkg::QTY_W-1:0]     quantity_next;
  logic [mrfr_pkg::READING_W-1:0] reading_next;
  logic                           matches_next;
  logic [mrfr_pkg::READING_W-1:0] b1_w;
  logic [mrfr_pkg::READING_W-1:0] b2_w;
  logic [mrfr_pkg::READING_W-1:0] b3_w;
  logic                           take;

  assign frame_ready = !result.valid || result.ready;
  assign take        = frame_valid && frame_ready;

  assign b1_w = mrfr_pkg::READING_W'(frame.b1);
  assign b2_w = mrfr_pkg::READING_W'(frame.b2);
  assign b3_w = mrfr_pkg::READING_W'(frame.b3);

  // Decode by reply code and setup phase
  always_comb begin
    status_next   = mrfr_pkg::STATUS_IGNORED;
    quantity_next = mrfr_pkg::QTY_VOLTAGE;
    reading_next  = '0;
    if (frame.bad_sum) begin
      status_next = mrfr_pkg::STATUS_BAD_SUM;
    end else begin
      case (frame.code)
        mrfr_pkg::CODE_VOLTAGE: begin
          if (!cfg.address_setup_mode) begin
            status_next   = mrfr_pkg::STATUS_DECODED;
            quantity_next = mrfr_pkg::QTY_VOLTAGE;
            reading_next  = b1_w * mrfr_pkg::VOLT_HI_SCALE +
                            b2_w * mrfr_pkg::VOLT_MID_SCALE + b3_w;
          end
        end
        mrfr_pkg::CODE_CURRENT: begin
          if (!cfg.address_setup_mode) begin
            status_next   = mrfr_pkg::STATUS_DECODED;
            quantity_next = mrfr_pkg::QTY_CURRENT;
            reading_next  = b1_w * mrfr_pkg::CURR_HI_SCALE +
                            b2_w * mrfr_pkg::CURR_MID_SCALE + b3_w;
          end
        end
        mrfr_pkg::CODE_POWER: begin
          if (!cfg.address_setup_mode) begin
            status_next   = mrfr_pkg::STATUS_DECODED;
            quantity_next = mrfr_pkg::QTY_POWER;
            reading_next  = {b1_w[mrfr_pkg::READING_W-9:0], 8'd0} + b2_w;
          end
        end
        mrfr_pkg::CODE_ADDR: begin
          if (cfg.address_setup_mode) begin
            status_next   = mrfr_pkg::STATUS_DECODED;
            quantity_next = mrfr_pkg::QTY_ADDR;
          end
        end
        // energy, alarm: ignored
        default: ;
      endcase
    end
    matches_next = (status_next == mrfr_pkg::STATUS_DECODED) &&
                   (quantity_next == cfg.pending_request);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.frame_status    <= status_next;
      result.quantity        <= quantity_next;
      result.reading         <= reading_next;
      result.matches_request <= matches_next;
    end
  end

endmodule

[rtl/meter_reply_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Meter reply frame receiver
// Parses seven-byte meter replies with an 8-bit sum check and decodes the
// measured quantity.
//
//   Channel  Dir  Word                                   Handshake
//   rx       in   rx_byte                                valid/ready
//   result   out  frame_status, quantity, reading,       valid/ready
//                 matches_request
//   cfg      in   index, data                            valid/ready
//
// One byte is taken per cycle while rx is not stalled; the collector's counter
// and running sum keep pace with no gaps. A result passes through the frame
// register, then the result register, after the checksum byte is taken.
// Reset (rst, synchronous) returns to hunting and clears both valid flags.
// Only the checksum byte waits on a full frame register; other bytes are
// taken even while the result side stalls.
// ----------------------------------------------------------------------------
`include "meter_reply_frame_receiver_macros.svh"

module meter_reply_frame_receiver (
  input  logic           clk,
  input  logic           rst,
  mrfr_byte_if.sink      rx,
  mrfr_result_if.source  result,
  mrfr_cfg_if.sink       cfg
);

  logic              frame_valid;
  logic              frame_ready;
  mrfr_pkg::frame_t  frame;
  mrfr_pkg::cfg_t    cfg_regs;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mrfr_pkg::CFG_PENDING_REQUEST: cfg_regs.pending_request <= cfg.data;
        mrfr_pkg::CFG_SETUP_MODE:      cfg_regs.address_setup_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Byte collection
  mrfr_collector u_collector (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Decode and result register
  mrfr_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .cfg         (cfg_regs),
    .result      (result)
  );

  // A frame handed to the decoder shows up as a result
  `MRFR_ASSERT_NEXT(a_frame_to_result, clk, rst, frame_valid && frame_ready, result.valid)
  // Failed or ignored frames carry no quantity, reading or match
  `MRFR_ASSERT_IMPLIES(a_reject_clean, clk, rst, result.valid && result.frame_status != mrfr_pkg::STATUS_DECODED, result.reading == '0 && !result.matches_request && result.quantity == mrfr_pkg::QTY_VOLTAGE)
  // Address acknowledgements have no reading
  `MRFR_ASSERT_IMPLIES(a_ack_no_reading, clk, rst, result.valid && result.quantity == mrfr_pkg::QTY_ADDR, result.reading == '0)
  // Byte input only stalls behind a full frame register
  `MRFR_ASSERT_IMPLIES(a_stall_cause, clk, rst, !rx.ready, frame_valid && !frame_ready)

endmodule

[dv/tb_meter_reply_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Meter reply frame receiver testbench
// Feeds serial bytes (clean frames, bad sums, noise and cut-off frames) under
// several request/setup settings, predicts each frame result in step with
// accepted bytes and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_meter_reply_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 6;     // checksum byte to result word, with margin
  localparam int HOLD_CYCLES   = 400;   // long result-side hold-off
  localparam int QUIET_LIMIT   = 4000;  // cycles with no accepted word
  localparam int PHASE_BYTES   = 103;
  localparam int NUM_PHASES    = 10;

  // Register indexes with no register behind them
  localparam logic [mrfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [mrfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [mrfr_pkg::STATUS_W-1:0]  frame_status;
    logic [mrfr_pkg::QTY_W-1:0]     quantity;
    logic [mrfr_pkg::READING_W-1:0] reading;
    logic                           matches_request;
  } reply_result_t;

  logic clk = 1'b0;
  logic rst;

  mrfr_byte_if   rx_if ();
  mrfr_result_if res_if ();
  mrfr_cfg_if    cfg_if ();

  meter_reply_frame_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #4 clk = ~clk;

  // Stimulus and expected results
  logic [mrfr_pkg::BYTE_W-1:0] serial_bytes_q[$];
  reply_result_t               reply_results_q[$];

  // Shadow of the frame collector and live registers
  logic [mrfr_pkg::POS_W-1:0]  hunt_pos;
  logic [mrfr_pkg::BYTE_W-1:0] frame_buf [0:5];
  logic [mrfr_pkg::BYTE_W-1:0] frame_sum;
  logic [mrfr_pkg::QTY_W-1:0]  req_shadow;
  logic                        setup_shadow;

  // Handshake pacing
  logic rx_taken;
  bit   idle_tx;
  bit   idle_rx;
  int   tx_gap;
  int   rx_gap;
  int   hold_requests;
  int   hold_served;
  int   hold_left;
  int   quiet_cycles;
  int   mismatch_count;

  // Result of a finished frame, given its checksum byte
  function automatic reply_result_t decode_reply(input logic [mrfr_pkg::BYTE_W-1:0] check);
    reply_result_t                  r;
    logic [mrfr_pkg::READING_W-1:0] b1, b2, b3;
    b1 = mrfr_pkg::READING_W'(frame_buf[1]);
    b2 = mrfr_pkg::READING_W'(frame_buf[2]);
    b3 = mrfr_pkg::READING_W'(frame_buf[3]);
    r = '{frame_status: mrfr_pkg::STATUS_IGNORED, quantity: mrfr_pkg::QTY_VOLTAGE,
          reading: '0, matches_request: 1'b0};
    if (check != frame_sum) begin
      r.frame_status = mrfr_pkg::STATUS_BAD_SUM;
      return r;
    end
    case (frame_buf[0])
      mrfr_pkg::CODE_VOLTAGE: if (!setup_shadow) begin
        r.frame_status = mrfr_pkg::STATUS_DECODED;
        r.quantity     = mrfr_pkg::QTY_VOLTAGE;
        r.reading      = b1 * 23'd2560 + b2 * 23'd10 + b3;
      end
      mrfr_pkg::CODE_CURRENT: if (!setup_shadow) begin
        r.frame_status = mrfr_pkg::STATUS_DECODED;
        r.quantity     = mrfr_pkg::QTY_CURRENT;
        r.reading      = b1 * 23'd25600 + b2 * 23'd100 + b3;
      end
      mrfr_pkg::CODE_POWER: if (!setup_shadow) begin
        r.frame_status = mrfr_pkg::STATUS_DECODED;
        r.quantity     = mrfr_pkg::QTY_POWER;
        r.reading      = b1 * 23'd256 + b2;
      end
      mrfr_pkg::CODE_ADDR: if (setup_shadow) begin
        r.frame_status = mrfr_pkg::STATUS_DECODED;
        r.quantity     = mrfr_pkg::QTY_ADDR;
      end
      default: ;  // energy and alarm replies stay ignored
    endcase
    if (r.frame_status == mrfr_pkg::STATUS_DECODED)
      r.matches_request = (r.quantity == req_shadow);
    return r;
  endfunction

  // Advance the collector shadow by one accepted byte
  task automatic track_serial_byte(input logic [mrfr_pkg::BYTE_W-1:0] b);
    if (hunt_pos == mrfr_pkg::POS_HUNT) begin
      if (b >= mrfr_pkg::CODE_VOLTAGE && b <= mrfr_pkg::CODE_ALARM) begin
        frame_buf[0] = b;
        frame_sum    = b;
        hunt_pos     = 3'd1;
      end
    end else if (hunt_pos < mrfr_pkg::POS_SUM) begin
      frame_buf[hunt_pos] = b;
      frame_sum           = frame_sum + b;
      hunt_pos            = hunt_pos + 3'd1;
    end else begin
      hunt_pos = mrfr_pkg::POS_HUNT;
      reply_results_q.push_back(decode_reply(b));
      frame_sum = '0;
    end
  endtask

  // Data byte, leaning on the extremes
  function automatic logic [mrfr_pkg::BYTE_W-1:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return mrfr_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Seven-byte frame; a nonzero sum_offset breaks the checksum
  task automatic push_frame(input logic [mrfr_pkg::BYTE_W-1:0] code,
                            input logic [mrfr_pkg::BYTE_W-1:0] b1,
                            input logic [mrfr_pkg::BYTE_W-1:0] b2,
                            input logic [mrfr_pkg::BYTE_W-1:0] b3,
                            input logic [mrfr_pkg::BYTE_W-1:0] sum_offset);
    logic [mrfr_pkg::BYTE_W-1:0] b4, b5, sum;
    b4  = data_byte();
    b5  = data_byte();
    sum = code + b1 + b2 + b3 + b4 + b5 + sum_offset;
    serial_bytes_q.push_back(code);
    serial_bytes_q.push_back(b1);
    serial_bytes_q.push_back(b2);
    serial_bytes_q.push_back(b3);
    serial_bytes_q.push_back(b4);
    serial_bytes_q.push_back(b5);
    serial_bytes_q.push_back(sum);
  endtask

  // Mostly clean frames, some bad sums, noise and cut-off frames
  task automatic push_random_bytes(input int target);
    int                          start;
    int                          n;
    logic [mrfr_pkg::BYTE_W-1:0] code;
    start = serial_bytes_q.size();
    while (serial_bytes_q.size() - start < target) begin
      code = mrfr_pkg::BYTE_W'(mrfr_pkg::CODE_VOLTAGE + $urandom_range(0, 5));
      if (setup_shadow && $urandom_range(0, 2) == 0)
        code = mrfr_pkg::CODE_ADDR;
      case ($urandom_range(0, 19)) inside
        [0:13]:  push_frame(code, data_byte(), data_byte(), data_byte(), 8'h00);
        [14:15]: push_frame(code, data_byte(), data_byte(), data_byte(),
                            mrfr_pkg::BYTE_W'($urandom_range(1, 255)));
        [16:17]: begin
          n = $urandom_range(1, 4);
          repeat (n) serial_bytes_q.push_back(mrfr_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        default: begin
          n = $urandom_range(0, 4);
          serial_bytes_q.push_back(code);
          repeat (n) serial_bytes_q.push_back(data_byte());
        end
      endcase
    end
  endtask

  // Register write; shadow follows on acceptance
  task automatic write_reg(input logic [mrfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mrfr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == mrfr_pkg::CFG_PENDING_REQUEST)
      req_shadow = val[mrfr_pkg::QTY_W-1:0];
    else if (idx == mrfr_pkg::CFG_SETUP_MODE)
      setup_shadow = val[0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Sender has nothing left and every result has come back
  task automatic wait_replies_drained();
    do @(posedge clk);
    while (serial_bytes_q.size() != 0 || rx_if.valid || reply_results_q.size() != 0);
  endtask

  // Byte driver
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        rx_if.valid <= 1'b0;
      end else if (idle_tx && $urandom_range(0, 9) == 0) begin
        tx_gap = $urandom_range(1, 12) - 1;
        rx_if.valid <= 1'b0;
      end else if (serial_bytes_q.size() > 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= serial_bytes_q.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Result-side ready: long hold-off on request, else random bursts
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      res_if.ready <= 1'b0;
    end else if (idle_rx && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 12) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Predict on every accepted byte
  always @(posedge clk) begin
    if (rst) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= rx_if.valid && rx_if.ready;
      if (rx_if.valid && rx_if.ready)
        track_serial_byte(rx_if.rx_byte);
    end
  end

  // Check every accepted result word against the oldest expectation
  always @(posedge clk) begin
    reply_result_t exp_r;
    if (!rst && res_if.valid && res_if.ready) begin
      if (reply_results_q.size() == 0) begin
        $error("result word with nothing expected: frame_status %0d quantity %0d reading %0d",
               res_if.frame_status, res_if.quantity, res_if.reading);
        mismatch_count++;
      end else begin
        exp_r = reply_results_q.pop_front();
        if (res_if.frame_status !== exp_r.frame_status) begin
          $error("frame_status mismatch: expected %0d, actual %0d",
                 exp_r.frame_status, res_if.frame_status);
          mismatch_count++;
        end
        if (res_if.quantity !== exp_r.quantity) begin
          $error("quantity mismatch: expected %0d, actual %0d",
                 exp_r.quantity, res_if.quantity);
          mismatch_count++;
        end
        if (res_if.reading !== exp_r.reading) begin
          $error("reading mismatch: expected %0d, actual %0d",
                 exp_r.reading, res_if.reading);
          mismatch_count++;
        end
        if (res_if.matches_request !== exp_r.matches_request) begin
          $error("matches_request mismatch: expected %0d, actual %0d",
                 exp_r.matches_request, res_if.matches_request);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on any channel
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** meter_reply_frame_receiver: FAILED **");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst            = 1'b1;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    hunt_pos       = mrfr_pkg::POS_HUNT;
    frame_sum      = '0;
    req_shadow     = mrfr_pkg::QTY_VOLTAGE;
    setup_shadow   = 1'b0;
    idle_tx        = 1'b1;
    idle_rx        = 1'b1;
    tx_gap         = 0;
    rx_gap         = 0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    for (int i = 0; i < 6; i++) frame_buf[i] = '0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: dropped noise, full-scale current, bad sum, then ack in setup
    serial_bytes_q.push_back(8'h00);
    serial_bytes_q.push_back(8'hFF);
    push_frame(mrfr_pkg::CODE_CURRENT, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    push_frame(mrfr_pkg::CODE_VOLTAGE, 8'h00, 8'h00, 8'h00, 8'h01);
    wait_replies_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(mrfr_pkg::CFG_SETUP_MODE, 2'd1);
    write_reg(mrfr_pkg::CFG_PENDING_REQUEST, mrfr_pkg::QTY_ADDR);
    push_frame(mrfr_pkg::CODE_ADDR, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_replies_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0: begin
          write_reg(mrfr_pkg::CFG_PENDING_REQUEST, mrfr_pkg::QTY_ADDR);
          write_reg(mrfr_pkg::CFG_SETUP_MODE, 2'd1);
        end
        1: begin
          write_reg(mrfr_pkg::CFG_PENDING_REQUEST, mrfr_pkg::QTY_VOLTAGE);
          write_reg(mrfr_pkg::CFG_SETUP_MODE, 2'd0);
        end
        default: begin
          write_reg(mrfr_pkg::CFG_PENDING_REQUEST,
                    mrfr_pkg::CFG_DATA_W'($urandom_range(0, 3)));
          write_reg(mrfr_pkg::CFG_SETUP_MODE,
                    mrfr_pkg::CFG_DATA_W'($urandom_range(0, 3)));
        end
      endcase
      if (p == 2) write_reg(CFG_SPARE_LO, mrfr_pkg::CFG_DATA_W'($urandom_range(0, 3)));
      if (p == 6) write_reg(CFG_SPARE_HI, mrfr_pkg::CFG_DATA_W'($urandom_range(0, 3)));

      idle_tx = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      idle_rx = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);

      if (p == 3) begin
        // Result side holds off while bytes keep coming; input must stall
        idle_tx = 1'b0;
        hold_requests++;
        push_random_bytes(PHASE_BYTES);
      end else if (p == 5) begin
        // Sender pauses mid-phase until every result is back
        push_random_bytes(PHASE_BYTES / 2);
        wait_replies_drained();
        push_random_bytes(PHASE_BYTES - PHASE_BYTES / 2);
      end else begin
        push_random_bytes(PHASE_BYTES);
      end
    end

    wait_replies_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reply_results_q.size() == 0) begin
      $display("** meter_reply_frame_receiver: PASSED **");
    end else begin
      $display("** meter_reply_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mrfr_pkg.sv
rtl/mrfr_byte_if.sv
rtl/mrfr_result_if.sv
rtl/mrfr_cfg_if.sv
rtl/mrfr_collector.sv
rtl/mrfr_decoder.sv
rtl/meter_reply_frame_receiver.sv
dv/tb_meter_reply_frame_receiver.sv
